/* sv/ikf_pkg.sv */
// ----------------------------------------------------------------------------
// ikf_pkg - shared types and helpers for the IMU angle Kalman filter
// Saturation helpers, unit command struct and register indexes.
// ----------------------------------------------------------------------------
package ikf_pkg;

   localparam int unsigned CFG_W   = 47;   // widest config register
   localparam int unsigned COV_W   = 48;   // covariance width, 40 frac bits
   localparam int unsigned ANG_W   = 32;   // Q16.16 sample width
   localparam int unsigned DT_W    = 32;   // sample period width
   localparam int unsigned OP_W    = 64;   // shared multiplier operand width
   localparam int unsigned SUM_W   = 66;   // exact state update sums
   localparam int unsigned DEN_W   = 49;   // R + P00
   localparam int unsigned CSR_A_W = 2;

   localparam logic [CSR_A_W-1:0] REG_Q_ANGLE = 2'd0;
   localparam logic [CSR_A_W-1:0] REG_Q_GYRO  = 2'd1;
   localparam logic [CSR_A_W-1:0] REG_R_ANGLE = 2'd2;
   localparam logic [CSR_A_W-1:0] REG_DT      = 2'd3;

   localparam logic signed [SUM_W-1:0] S48_MAX = 66'sd140737488355327;
   localparam logic signed [SUM_W-1:0] S48_MIN = -66'sd140737488355328;
   localparam logic signed [SUM_W-1:0] S32_MAX = 66'sd2147483647;
   localparam logic signed [SUM_W-1:0] S32_MIN = -66'sd2147483648;

   typedef struct packed {
      logic start;
      logic sh40;    // rescale by 2^40 instead of 2^32
   } mul_cmd_type;

   function automatic logic signed [COV_W-1:0] sat48(input logic signed [SUM_W-1:0] x);
      logic signed [SUM_W-1:0] y;
      y = (x > S48_MAX) ? S48_MAX : ((x < S48_MIN) ? S48_MIN : x);
      return y[COV_W-1:0];
   endfunction

   function automatic logic signed [ANG_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
      logic signed [SUM_W-1:0] y;
      y = (x > S32_MAX) ? S32_MAX : ((x < S32_MIN) ? S32_MIN : x);
      return y[ANG_W-1:0];
   endfunction

endpackage

/* sv/imu_angle_kalman_filter.sv */
// ----------------------------------------------------------------------------
// imu_angle_kalman_filter - two-state angle / gyro bias Kalman filter
// One sample in, one fused angle and bias-corrected rate out.
// ----------------------------------------------------------------------------
//  channel  ports                               beat
//  req      req_valid/req_ready, accel, gyro    one IMU sample
//  rsp      rsp_valid/rsp_ready, angle, rate    one filtered result
//  csr      csr_we, csr_addr, csr_wdata         one register write
//
//  Each sample makes ten passes through the shared rounding multiplier
//  and runs two gains through the serial divider (88 steps each).
//  req_ready is high only while idle; the result holds in rsp_* until taken.
//  Reset is synchronous: estimates clear, covariance goes to identity,
//  registers take their defaults.
// ----------------------------------------------------------------------------
module imu_angle_kalman_filter (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [ikf_pkg::ANG_W-1:0]     req_accel_angle,
   input  logic signed [ikf_pkg::ANG_W-1:0]     req_gyro_rate,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [ikf_pkg::ANG_W-1:0]     rsp_fused_angle,
   output logic signed [ikf_pkg::ANG_W-1:0]     rsp_fused_rate,
   input  logic                                 csr_we,
   input  logic [ikf_pkg::CSR_A_W-1:0]          csr_addr,
   input  logic [ikf_pkg::CFG_W-1:0]            csr_wdata
);
   import ikf_pkg::*;

   // sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_WAIT  = 2'd2;
   localparam logic [1:0] ST_OUT   = 2'd3;

   // operation steps, in model order
   localparam logic [3:0] STEP_ANG  = 4'd0;   // predict angle
   localparam logic [3:0] STEP_P00  = 4'd1;   // predict P00
   localparam logic [3:0] STEP_P01  = 4'd2;   // predict P01 and P10
   localparam logic [3:0] STEP_P11  = 4'd3;   // predict P11
   localparam logic [3:0] STEP_K0   = 4'd4;   // gain K0
   localparam logic [3:0] STEP_K1   = 4'd5;   // gain K1
   localparam logic [3:0] STEP_C00  = 4'd6;
   localparam logic [3:0] STEP_C01  = 4'd7;
   localparam logic [3:0] STEP_C10  = 4'd8;
   localparam logic [3:0] STEP_C11  = 4'd9;
   localparam logic [3:0] STEP_ANGC = 4'd10;  // correct angle
   localparam logic [3:0] STEP_BIAS = 4'd11;  // correct bias, then emit

   // config registers
   logic [CFG_W-1:0] q_angle_ff, q_angle_in, q_gyro_ff, q_gyro_in, r_angle_ff, r_angle_in;
   logic [DT_W-1:0]  dt_ff, dt_in;

   // filter state
   logic signed [ANG_W-1:0] angle_ff, angle_in, bias_ff, bias_in;
   logic signed [COV_W-1:0] p00_ff, p00_in, p01_ff, p01_in, p10_ff, p10_in, p11_ff, p11_in;

   // per-sample work registers
   logic [1:0]              state_ff, state_in;
   logic [3:0]              step_ff, step_in;
   logic signed [ANG_W-1:0] accel_ff, accel_in, gyro_ff, gyro_in;
   logic signed [ANG_W:0]   err_ff, err_in;
   logic signed [COV_W-1:0] t0_ff, t0_in, t1_ff, t1_in, k0_ff, k0_in, k1_ff, k1_in;
   logic signed [ANG_W-1:0] out_angle_ff, out_angle_in, out_rate_ff, out_rate_in;

   // shared units
   mul_cmd_type             mul_cmd;
   logic                    mul_start, mul_sh40;
   logic signed [OP_W-1:0]  mul_a, mul_b, mul_res;
   logic                    mul_done, div_start, div_done;
   logic signed [COV_W-1:0] div_num, div_res;
   logic signed [DEN_W-1:0] den;
   logic                    step_is_div, unit_done;

   logic signed [SUM_W-1:0] m66;

   assign step_is_div = (step_ff == STEP_K0) || (step_ff == STEP_K1);
   assign unit_done   = step_is_div ? div_done : mul_done;
   assign den     = $signed({2'b00, r_angle_ff}) + DEN_W'(p00_ff);
   assign div_num = (step_ff == STEP_K0) ? p00_ff : p10_ff;
   assign m66     = SUM_W'(mul_res);
   assign mul_cmd = '{start: mul_start, sh40: mul_sh40};

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = $signed({32'd0, dt_ff});
      mul_sh40 = 1'b1;
      case (step_ff)
         STEP_ANG: begin
            mul_a = OP_W'(gyro_ff) - OP_W'(bias_ff);
            mul_sh40 = 1'b0;
         end
         STEP_P00: begin
            mul_a = $signed({17'd0, q_angle_ff}) - OP_W'(p01_ff) - OP_W'(p10_ff);
            mul_sh40 = 1'b0;
         end
         STEP_P01: begin
            mul_a = -OP_W'(p11_ff);
            mul_sh40 = 1'b0;
         end
         STEP_P11: begin
            mul_a = $signed({17'd0, q_gyro_ff});
            mul_sh40 = 1'b0;
         end
         STEP_C00:  begin mul_a = OP_W'(k0_ff); mul_b = OP_W'(t0_ff);  end
         STEP_C01:  begin mul_a = OP_W'(k0_ff); mul_b = OP_W'(t1_ff);  end
         STEP_C10:  begin mul_a = OP_W'(k1_ff); mul_b = OP_W'(t0_ff);  end
         STEP_C11:  begin mul_a = OP_W'(k1_ff); mul_b = OP_W'(t1_ff);  end
         STEP_ANGC: begin mul_a = OP_W'(k0_ff); mul_b = OP_W'(err_ff); end
         STEP_BIAS: begin mul_a = OP_W'(k1_ff); mul_b = OP_W'(err_ff); end
         default: ;
      endcase
   end

   // sequencer and write-back
   always_comb begin
      q_angle_in   = q_angle_ff;
      q_gyro_in    = q_gyro_ff;
      r_angle_in   = r_angle_ff;
      dt_in        = dt_ff;
      angle_in     = angle_ff;
      bias_in      = bias_ff;
      p00_in       = p00_ff;
      p01_in       = p01_ff;
      p10_in       = p10_ff;
      p11_in       = p11_ff;
      state_in     = state_ff;
      step_in      = step_ff;
      accel_in     = accel_ff;
      gyro_in      = gyro_ff;
      err_in       = err_ff;
      t0_in        = t0_ff;
      t1_in        = t1_ff;
      k0_in        = k0_ff;
      k1_in        = k1_ff;
      out_angle_in = out_angle_ff;
      out_rate_in  = out_rate_ff;
      mul_start    = 1'b0;
      div_start    = 1'b0;

      if (csr_we) begin
         case (csr_addr)
            REG_Q_ANGLE: q_angle_in = csr_wdata;
            REG_Q_GYRO:  q_gyro_in  = csr_wdata;
            REG_R_ANGLE: r_angle_in = csr_wdata;
            REG_DT:      dt_in      = csr_wdata[DT_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               accel_in = req_accel_angle;
               gyro_in  = req_gyro_rate;
               step_in  = STEP_ANG;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (step_is_div) div_start = 1'b1;
            else mul_start = 1'b1;
            if (step_ff == STEP_K0) begin
               // predicted P00/P01 and innovation, held for the correction
               t0_in  = p00_ff;
               t1_in  = p01_ff;
               err_in = (ANG_W+1)'(accel_ff) - (ANG_W+1)'(angle_ff);
            end
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (unit_done) begin
               state_in = ST_ISSUE;
               step_in  = step_ff + 4'd1;
               case (step_ff)
                  STEP_ANG:  angle_in = sat32(SUM_W'(angle_ff) + m66);
                  STEP_P00:  p00_in = sat48(SUM_W'(p00_ff) + m66);
                  STEP_P01: begin
                     p01_in = sat48(SUM_W'(p01_ff) + m66);
                     p10_in = sat48(SUM_W'(p10_ff) + m66);
                  end
                  STEP_P11:  p11_in = sat48(SUM_W'(p11_ff) + m66);
                  STEP_K0:   k0_in = div_res;
                  STEP_K1:   k1_in = div_res;
                  STEP_C00:  p00_in = sat48(SUM_W'(p00_ff) - m66);
                  STEP_C01:  p01_in = sat48(SUM_W'(p01_ff) - m66);
                  STEP_C10:  p10_in = sat48(SUM_W'(p10_ff) - m66);
                  STEP_C11:  p11_in = sat48(SUM_W'(p11_ff) - m66);
                  STEP_ANGC: angle_in = sat32(SUM_W'(angle_ff) + m66);
                  STEP_BIAS: begin
                     bias_in      = sat32(SUM_W'(bias_ff) + m66);
                     out_angle_in = angle_ff;
                     out_rate_in  = sat32(SUM_W'(gyro_ff) - SUM_W'(bias_in));
                     step_in      = STEP_ANG;
                     state_in     = ST_OUT;
                  end
                  default: ;
               endcase
            end
         end
         ST_OUT: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_angle_ff <= 47'd1099512;
         q_gyro_ff  <= 47'd109951163;
         r_angle_ff <= 47'd549755813888;
         dt_ff      <= 32'd8589935;
         angle_ff   <= '0;
         bias_ff    <= '0;
         p00_ff     <= 48'sd1099511627776;
         p01_ff     <= '0;
         p10_ff     <= '0;
         p11_ff     <= 48'sd1099511627776;
         state_ff   <= ST_IDLE;
         step_ff    <= STEP_ANG;
      end else begin
         q_angle_ff <= q_angle_in;
         q_gyro_ff  <= q_gyro_in;
         r_angle_ff <= r_angle_in;
         dt_ff      <= dt_in;
         angle_ff   <= angle_in;
         bias_ff    <= bias_in;
         p00_ff     <= p00_in;
         p01_ff     <= p01_in;
         p10_ff     <= p10_in;
         p11_ff     <= p11_in;
         state_ff   <= state_in;
         step_ff    <= step_in;
      end
      accel_ff     <= accel_in;
      gyro_ff      <= gyro_in;
      err_ff       <= err_in;
      t0_ff        <= t0_in;
      t1_ff        <= t1_in;
      k0_ff        <= k0_in;
      k1_ff        <= k1_in;
      out_angle_ff <= out_angle_in;
      out_rate_ff  <= out_rate_in;
   end

   ikf_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .cmd    (mul_cmd),
      .a      (mul_a),
      .b      (mul_b),
      .done   (mul_done),
      .result (mul_res)
   );

   ikf_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (div_num),
      .den    (den),
      .done   (div_done),
      .result (div_res)
   );

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = (state_ff == ST_OUT);
   assign rsp_fused_angle = out_angle_ff;
   assign rsp_fused_rate  = out_rate_ff;

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> step_ff <= STEP_BIAS) else $error("step out of range");
   a_unit_idle_wait: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_WAIT |-> !mul_done && !div_done) else $error("stray unit done");
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WAIT && !unit_done |=> state_ff == ST_WAIT)
      else $error("sequencer left wait early");
   a_issue_once: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ISSUE |=> state_ff == ST_WAIT) else $error("issue not followed by wait");

endmodule

/* sv/ikf_mul.sv */
// ----------------------------------------------------------------------------
// ikf_mul - shared rounding multiplier
// Signed 64x64 multiply from four 32x32 partial products, rounded to nearest
// (ties away from zero), shifted by 32 or 40 and clamped to +-(2^62 - 1).
// ----------------------------------------------------------------------------
module ikf_mul (
   input  logic                              clock,
   input  logic                              reset,
   input  ikf_pkg::mul_cmd_type              cmd,
   input  logic signed [ikf_pkg::OP_W-1:0]   a,
   input  logic signed [ikf_pkg::OP_W-1:0]   b,
   output logic                              done,
   output logic signed [ikf_pkg::OP_W-1:0]   result
);
   import ikf_pkg::*;

   localparam logic [127:0] LIM62 = 128'h3FFF_FFFF_FFFF_FFFF;

   logic              busy_ff, busy_in;
   logic [2:0]        cnt_ff, cnt_in;
   logic [OP_W-1:0]   xa_ff, xa_in, xb_ff, xb_in;
   logic              neg_ff, neg_in, sh40_ff, sh40_in;
   logic [63:0]       prod_ff, prod_in;
   logic [1:0]        pshift_ff, pshift_in;
   logic              pvalid_ff, pvalid_in;
   logic [127:0]      acc_ff, acc_in;
   logic [62:0]       q_ff, q_in;
   logic              done_ff, done_in;
   logic signed [OP_W-1:0] result_ff, result_in;

   logic [127:0] rsum, rq;
   logic [31:0]  ha, hb;

   always_comb begin
      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      xa_in     = xa_ff;
      xb_in     = xb_ff;
      neg_in    = neg_ff;
      sh40_in   = sh40_ff;
      prod_in   = prod_ff;
      pshift_in = pshift_ff;
      pvalid_in = 1'b0;
      acc_in    = acc_ff;
      q_in      = q_ff;
      done_in   = 1'b0;
      result_in = result_ff;
      ha = cnt_ff[0] ? xa_ff[63:32] : xa_ff[31:0];
      hb = cnt_ff[1] ? xb_ff[63:32] : xb_ff[31:0];
      rsum = acc_ff + (sh40_ff ? (128'd1 << 39) : (128'd1 << 31));
      rq   = sh40_ff ? (rsum >> 40) : (rsum >> 32);

      if (!busy_ff) begin
         if (cmd.start) begin
            busy_in = 1'b1;
            cnt_in  = 3'd0;
            xa_in   = a[OP_W-1] ? (~a + 1'b1) : a;
            xb_in   = b[OP_W-1] ? (~b + 1'b1) : b;
            neg_in  = a[OP_W-1] ^ b[OP_W-1];
            sh40_in = cmd.sh40;
            acc_in  = '0;
         end
      end else begin
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff < 3'd4) begin
            prod_in   = ha * hb;
            pshift_in = {1'b0, cnt_ff[0]} + {1'b0, cnt_ff[1]};
            pvalid_in = 1'b1;
         end
         if (pvalid_ff) begin
            case (pshift_ff)
               2'd0:    acc_in = acc_ff + {64'd0, prod_ff};
               2'd1:    acc_in = acc_ff + {32'd0, prod_ff, 32'd0};
               2'd2:    acc_in = acc_ff + {prod_ff, 64'd0};
               default: acc_in = acc_ff;
            endcase
         end
         if (cnt_ff == 3'd5) begin
            q_in = (rq > LIM62) ? LIM62[62:0] : rq[62:0];
         end
         if (cnt_ff == 3'd6) begin
            result_in = neg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});
            done_in   = 1'b1;
            busy_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         cnt_ff    <= '0;
         pvalid_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         cnt_ff    <= cnt_in;
         pvalid_ff <= pvalid_in;
         done_ff   <= done_in;
      end
      xa_ff     <= xa_in;
      xb_ff     <= xb_in;
      neg_ff    <= neg_in;
      sh40_ff   <= sh40_in;
      prod_ff   <= prod_in;
      pshift_ff <= pshift_in;
      acc_ff    <= acc_in;
      q_ff      <= q_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !cmd.start) else $error("multiplier started while busy");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff) else $error("done without a run");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff <= 3'd6) else $error("multiplier count out of range");

endmodule

/* sv/ikf_div.sv */
// ----------------------------------------------------------------------------
// ikf_div - serial gain divider
// (num * 2^40) / den, one restoring step per cycle, truncated toward zero,
// magnitude limited to 2^47 - 1, zero for a zero divisor.
// ----------------------------------------------------------------------------
module ikf_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [ikf_pkg::COV_W-1:0]   num,
   input  logic signed [ikf_pkg::DEN_W-1:0]   den,
   output logic                               done,
   output logic signed [ikf_pkg::COV_W-1:0]   result
);
   import ikf_pkg::*;

   localparam logic [6:0] I_TOP = 7'd87;

   logic              busy_ff, busy_in;
   logic [6:0]        i_ff, i_in;
   logic [COV_W-1:0]  n_ff, n_in;
   logic [DEN_W-1:0]  d_ff, d_in;
   logic [DEN_W-1:0]  r_ff, r_in;
   logic [46:0]       q_ff, q_in;
   logic              ovf_ff, ovf_in, neg_ff, neg_in;
   logic              done_ff, done_in;
   logic signed [COV_W-1:0] result_ff, result_in;

   logic [6:0]       nidx;
   logic             nbit;
   logic [DEN_W:0]   r2;
   logic [46:0]      qm;

   always_comb begin
      busy_in   = busy_ff;
      i_in      = i_ff;
      n_in      = n_ff;
      d_in      = d_ff;
      r_in      = r_ff;
      q_in      = q_ff;
      ovf_in    = ovf_ff;
      neg_in    = neg_ff;
      done_in   = 1'b0;
      result_in = result_ff;
      nidx = i_ff - 7'd40;
      nbit = (i_ff >= 7'd40) ? n_ff[nidx[5:0]] : 1'b0;
      r2   = {r_ff, nbit};
      qm   = '0;

      if (!busy_ff) begin
         if (start) begin
            if (den == '0) begin
               result_in = '0;
               done_in   = 1'b1;
            end else begin
               busy_in = 1'b1;
               i_in    = I_TOP;
               n_in    = num[COV_W-1] ? (~num + 1'b1) : num;
               d_in    = den[DEN_W-1] ? (~den + 1'b1) : den;
               r_in    = '0;
               q_in    = '0;
               ovf_in  = 1'b0;
               neg_in  = num[COV_W-1] ^ den[DEN_W-1];
            end
         end
      end else begin
         if (r2 >= {1'b0, d_ff}) begin
            r_in = r2[DEN_W-1:0] - d_ff;
            if (i_ff >= 7'd47) ovf_in = 1'b1;
            else q_in[i_ff[5:0]] = 1'b1;
         end else begin
            r_in = r2[DEN_W-1:0];
         end
         i_in = i_ff - 7'd1;
         if (i_ff == 7'd0) begin
            qm        = ovf_in ? '1 : q_in;
            result_in = neg_ff ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
            done_in   = 1'b1;
            busy_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         i_ff    <= '0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         i_ff    <= i_in;
         done_ff <= done_in;
      end
      n_ff      <= n_in;
      d_ff      <= d_in;
      r_ff      <= r_in;
      q_ff      <= q_in;
      ovf_ff    <= ovf_in;
      neg_ff    <= neg_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      busy_ff && $past(busy_ff) |-> r_ff < d_ff) else $error("remainder not reduced");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start) else $error("divider started while busy");
   a_i_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> i_ff <= I_TOP) else $error("divider step out of range");

endmodule
